[rtl/lzbad_pkg.sv]
// shared constants, codes and control structs of the lz binary arithmetic decoder
package lzbad_pkg;

    localparam int WINDOW_BYTES = 1048576;
    localparam int HIST_AW      = $clog2(WINDOW_BYTES);
    localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);

    localparam int NUM_MODELS   = 803;
    localparam int MODEL_AW     = $clog2(NUM_MODELS);
    localparam int MODEL_PREV   = 2;
    localparam int MODEL_LOW    = 3;
    localparam int MODEL_LIT    = 35;
    localparam int MODEL_G0     = 291;
    localparam int MODEL_G1     = 547;
    localparam int PROB_W       = 11;
    localparam int PROB_INIT    = 1024;
    localparam int PROB_ONE     = 2048;
    localparam logic [31:0] RANGE_TOP = 32'h0100_0000;

    localparam logic [1:0] ACT_SUPPLY  = 2'd0;
    localparam logic [1:0] ACT_PULL    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [2:0] ST_BYTE     = 3'd0;
    localparam logic [2:0] ST_NEED     = 3'd1;
    localparam logic [2:0] ST_END      = 3'd2;
    localparam logic [2:0] ST_REFUSED  = 3'd3;
    localparam logic [2:0] ST_OFFS_ERR = 3'd4;
    localparam logic [2:0] ST_ACCEPTED = 3'd5;

    typedef enum logic [2:0] {
        CO_NONE,
        CO_RESET,
        CO_LOAD,
        CO_NORM,
        CO_MUL,
        CO_RESOLVE
    } coder_op_t;

    typedef struct packed {
        coder_op_t           op;
        logic [7:0]          data;
        logic [PROB_W-1:0]   prob;
        logic                lit_shift;
    } coder_cmd_t;

    typedef struct packed {
        logic                need_norm;
        logic                bit_val;
        logic [PROB_W-1:0]   new_prob;
    } coder_stat_t;

endpackage

[rtl/lzbad_if.sv]
// valid/ready channel interfaces for decoder requests and results
interface lzbad_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink (input valid, input action, input in_byte, output ready);
endinterface

interface lzbad_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] out_byte;

    modport source (output valid, output status, output out_byte, input ready);
    modport sink (input valid, input status, input out_byte, output ready);
endinterface

[rtl/lz_binary_arith_decoder.sv]
// top level of the lz binary arithmetic decoder with its decode sequencer
// usage:
// request channel carries action and in_byte; result channel carries status
// and out_byte, exactly one result transaction per request transaction.
// supply, restart and unknown actions register their result on acceptance.
// a pull runs the sequencer until it has a byte or a status: each coded bit
// passes through dispatch, model read, bound multiply and resolve with model
// write; a copied match byte is read from the history window, and a new match
// header ends with an offset check after its coded bits.
// the request side is ready only while the sequencer is idle and the result
// register is free or being taken; a stalled receiver holds the result and
// blocks new requests. after reset and after every restart a clearing pass
// over all 803 probability models sets each to one half; no request is
// taken meanwhile. the history window is not cleared.
module lz_binary_arith_decoder
    import lzbad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lzbad_req_if.sink   request,
    lzbad_res_if.source result
);

    typedef enum logic [3:0] {
        PH_INIT, PH_CODE, PH_LIT, PH_PREV, PH_G0A, PH_G0B,
        PH_LOW, PH_G1A, PH_G1B, PH_COPY, PH_END, PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_BIT_RD, S_BIT_MUL, S_BIT_RES,
        S_OFFS, S_COPY
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [MODEL_AW-1:0] clr_reg, clr_next;
    logic [MODEL_AW-1:0] idx_reg, idx_next;
    logic lit_reg, lit_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [HIST_AW-1:0] hidx_reg, hidx_next;
    logic copy_rd_reg, copy_rd_next;
    logic [CNT_W-1:0] produced_reg, produced_next;
    logic [CNT_W-1:0] last_off_reg, last_off_next;
    logic after_reg, after_next;
    logic [31:0] copy_reg, copy_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic held_valid_reg, held_valid_next;
    logic [2:0] init_left_reg, init_left_next;
    logic [31:0] gamma_reg, gamma_next;
    logic [7:0] gctx_reg, gctx_next;
    logic [8:0] tree_reg, tree_next;
    logic [35:0] offs_reg, offs_next;
    logic bonus_en_reg, bonus_en_next;
    logic out_valid_reg, out_valid_next;
    logic [2:0] out_status_reg, out_status_next;
    logic [7:0] out_byte_reg, out_byte_next;

    coder_cmd_t  ccmd;
    coder_stat_t cstat;

    logic prob_we;
    logic [MODEL_AW-1:0] prob_waddr;
    logic [PROB_W-1:0] prob_wdata;
    logic [PROB_W-1:0] prob_rdata;
    logic hist_we;
    logic [7:0] hist_wdata;
    logic [7:0] hist_rdata;

    logic accept;
    logic [8:0] tree_bit;
    logic [31:0] gamma_bit;
    logic [31:0] gamma_t;
    logic [CNT_W:0] wp_ext;
    logic [CNT_W:0] hdiff;
    logic [1:0] bonus;

    lzbad_coder u_coder (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ccmd),
        .stat  (cstat)
    );

    lzbad_ram #(.WIDTH(PROB_W), .DEPTH(NUM_MODELS)) u_prob_ram (
        .clk   (clk),
        .we    (prob_we),
        .waddr (prob_waddr),
        .wdata (prob_wdata),
        .raddr (idx_reg),
        .rdata (prob_rdata)
    );

    lzbad_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (hist_wdata),
        .raddr (hidx_reg),
        .rdata (hist_rdata)
    );

    assign request.ready   = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept          = request.valid && request.ready;
    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.out_byte = out_byte_reg;

    assign tree_bit  = {tree_reg[7:0], cstat.bit_val};
    assign gamma_bit = {gamma_reg[30:0], cstat.bit_val};
    assign gamma_t   = gamma_reg - 32'd2;
    assign wp_ext    = (CNT_W + 1)'(wp_reg);
    assign hdiff     = (wp_ext >= {1'b0, last_off_reg})
                       ? (wp_ext - {1'b0, last_off_reg})
                       : (wp_ext + (CNT_W + 1)'(WINDOW_BYTES) - {1'b0, last_off_reg});
    assign bonus     = bonus_en_reg
                       ? (2'((offs_reg >= 36'd2048) ? 1 : 0) + 2'((offs_reg >= 36'd96) ? 1 : 0))
                       : 2'd0;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        lit_next        = lit_reg;
        prob_next       = prob_reg;
        wp_next         = wp_reg;
        hidx_next       = hidx_reg;
        copy_rd_next    = copy_rd_reg;
        produced_next   = produced_reg;
        last_off_next   = last_off_reg;
        after_next      = after_reg;
        copy_next       = copy_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        init_left_next  = init_left_reg;
        gamma_next      = gamma_reg;
        gctx_next       = gctx_reg;
        tree_next       = tree_reg;
        offs_next       = offs_reg;
        bonus_en_next   = bonus_en_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;

        ccmd.op        = CO_NONE;
        ccmd.data      = held_byte_reg;
        ccmd.prob      = prob_reg;
        ccmd.lit_shift = lit_reg;
        prob_we        = 1'b0;
        prob_waddr     = idx_reg;
        prob_wdata     = cstat.new_prob;
        hist_we        = 1'b0;
        hist_wdata     = tree_bit[7:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                prob_we    = 1'b1;
                prob_waddr = clr_reg;
                prob_wdata = PROB_W'(PROB_INIT);
                if (clr_reg == MODEL_AW'(NUM_MODELS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + MODEL_AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = 8'd0;
                    out_status_next = ST_REFUSED;
                    unique case (request.action)
                        ACT_RESTART:
                        begin
                            ccmd.op         = CO_RESET;
                            state_next      = S_CLEAR;
                            phase_next      = PH_INIT;
                            clr_next        = '0;
                            wp_next         = '0;
                            produced_next   = '0;
                            last_off_next   = '0;
                            after_next      = 1'b0;
                            copy_next       = '0;
                            held_byte_next  = '0;
                            held_valid_next = 1'b0;
                            init_left_next  = 3'd4;
                            gamma_next      = 32'd1;
                            gctx_next       = 8'd1;
                            tree_next       = 9'd1;
                            out_status_next = ST_ACCEPTED;
                        end
                        ACT_SUPPLY:
                        begin
                            if (phase_reg == PH_END || phase_reg == PH_ERR)
                            begin
                                out_status_next = ST_REFUSED;
                            end
                            else if (phase_reg == PH_INIT)
                            begin
                                ccmd.op         = CO_LOAD;
                                ccmd.data       = request.in_byte;
                                init_left_next  = init_left_reg - 3'd1;
                                if (init_left_reg == 3'd1)
                                begin
                                    tree_next  = 9'd1;
                                    phase_next = PH_LIT;
                                end
                                out_status_next = ST_ACCEPTED;
                            end
                            else if (held_valid_reg)
                            begin
                                out_status_next = ST_REFUSED;
                            end
                            else
                            begin
                                held_byte_next  = request.in_byte;
                                held_valid_next = 1'b1;
                                out_status_next = ST_ACCEPTED;
                            end
                        end
                        ACT_PULL:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_DISPATCH;
                        end
                        default:
                        begin
                            out_status_next = ST_REFUSED;
                        end
                    endcase
                end
            end
            S_DISPATCH:
            begin
                state_next = S_BIT_RD;
                lit_next   = 1'b0;
                unique case (phase_reg)
                    PH_INIT:
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_NEED;
                        out_byte_next   = 8'd0;
                        state_next      = S_IDLE;
                    end
                    PH_END:
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_END;
                        out_byte_next   = 8'd0;
                        state_next      = S_IDLE;
                    end
                    PH_ERR:
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OFFS_ERR;
                        out_byte_next   = 8'd0;
                        state_next      = S_IDLE;
                    end
                    PH_COPY:
                    begin
                        if (copy_reg == 32'd0)
                        begin
                            phase_next = PH_CODE;
                            state_next = S_DISPATCH;
                        end
                        else
                        begin
                            hidx_next    = hdiff[HIST_AW-1:0];
                            copy_rd_next = 1'b0;
                            state_next   = S_COPY;
                        end
                    end
                    PH_CODE:
                    begin
                        idx_next = MODEL_AW'(after_reg);
                    end
                    PH_LIT:
                    begin
                        idx_next = MODEL_AW'(MODEL_LIT) + MODEL_AW'(tree_reg[7:0]);
                        lit_next = 1'b1;
                    end
                    PH_PREV:
                    begin
                        idx_next = MODEL_AW'(MODEL_PREV);
                    end
                    PH_G0A, PH_G0B:
                    begin
                        idx_next = MODEL_AW'(MODEL_G0) + MODEL_AW'(gctx_reg);
                    end
                    PH_G1A, PH_G1B:
                    begin
                        idx_next = MODEL_AW'(MODEL_G1) + MODEL_AW'(gctx_reg);
                    end
                    PH_LOW:
                    begin
                        idx_next = MODEL_AW'(MODEL_LOW) + ((gamma_t != 32'd0)
                                   ? MODEL_AW'(16) : MODEL_AW'(0))
                                   + MODEL_AW'(tree_reg[3:0]);
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_BIT_RD:
            begin
                if (cstat.need_norm && !held_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_NEED;
                    out_byte_next   = 8'd0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    if (cstat.need_norm)
                    begin
                        ccmd.op         = CO_NORM;
                        held_valid_next = 1'b0;
                    end
                    state_next = S_BIT_MUL;
                end
            end
            S_BIT_MUL:
            begin
                ccmd.op    = CO_MUL;
                ccmd.prob  = prob_rdata;
                prob_next  = prob_rdata;
                state_next = S_BIT_RES;
            end
            S_BIT_RES:
            begin
                ccmd.op    = CO_RESOLVE;
                prob_we    = 1'b1;
                state_next = S_DISPATCH;
                unique case (phase_reg)
                    PH_CODE:
                    begin
                        if (!cstat.bit_val)
                        begin
                            tree_next  = 9'd1;
                            phase_next = PH_LIT;
                        end
                        else if (after_reg)
                        begin
                            gamma_next = 32'd1;
                            gctx_next  = 8'd1;
                            phase_next = PH_G0A;
                        end
                        else
                        begin
                            phase_next = PH_PREV;
                        end
                    end
                    PH_LIT:
                    begin
                        tree_next = tree_bit;
                        if (tree_bit[8])
                        begin
                            hist_we         = 1'b1;
                            hist_wdata      = tree_bit[7:0];
                            wp_next         = (wp_reg == HIST_AW'(WINDOW_BYTES - 1))
                                              ? '0 : wp_reg + HIST_AW'(1);
                            if (produced_reg < CNT_W'(WINDOW_BYTES))
                            begin
                                produced_next = produced_reg + CNT_W'(1);
                            end
                            after_next      = 1'b0;
                            phase_next      = PH_CODE;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_BYTE;
                            out_byte_next   = tree_bit[7:0];
                            state_next      = S_IDLE;
                        end
                    end
                    PH_PREV:
                    begin
                        if (cstat.bit_val)
                        begin
                            offs_next     = 36'(last_off_reg);
                            bonus_en_next = 1'b0;
                            state_next    = S_OFFS;
                        end
                        else
                        begin
                            gamma_next = 32'd1;
                            gctx_next  = 8'd1;
                            phase_next = PH_G0A;
                        end
                    end
                    PH_G0A:
                    begin
                        gctx_next  = {gctx_reg[6:0], cstat.bit_val};
                        phase_next = PH_G0B;
                    end
                    PH_G1A:
                    begin
                        gctx_next  = {gctx_reg[6:0], cstat.bit_val};
                        phase_next = PH_G1B;
                    end
                    PH_G0B, PH_G1B:
                    begin
                        gamma_next = gamma_bit;
                        gctx_next  = {gctx_reg[6:0], cstat.bit_val};
                        if (gctx_reg[0])
                        begin
                            phase_next = (phase_reg == PH_G0B) ? PH_G0A : PH_G1A;
                        end
                        else if (phase_reg == PH_G0B)
                        begin
                            if (gamma_bit == 32'd0)
                            begin
                                phase_next = PH_END;
                            end
                            else
                            begin
                                tree_next  = 9'd1;
                                phase_next = PH_LOW;
                            end
                        end
                        else
                        begin
                            copy_next  = copy_reg + gamma_bit;
                            phase_next = PH_COPY;
                        end
                    end
                    PH_LOW:
                    begin
                        tree_next = tree_bit;
                        if (tree_bit[4])
                        begin
                            offs_next     = {gamma_t, 4'd0} + 36'(tree_bit[3:0]) + 36'd1;
                            bonus_en_next = 1'b1;
                            state_next    = S_OFFS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_OFFS:
            begin
                state_next = S_DISPATCH;
                if (offs_reg == 36'd0 || offs_reg > 36'(produced_reg))
                begin
                    phase_next = PH_ERR;
                end
                else
                begin
                    last_off_next = offs_reg[CNT_W-1:0];
                    after_next    = 1'b1;
                    copy_next     = 32'(bonus);
                    gamma_next    = 32'd1;
                    gctx_next     = 8'd1;
                    phase_next    = PH_G1A;
                end
            end
            S_COPY:
            begin
                if (!copy_rd_reg)
                begin
                    copy_rd_next = 1'b1;
                end
                else
                begin
                    hist_we         = 1'b1;
                    hist_wdata      = hist_rdata;
                    wp_next         = (wp_reg == HIST_AW'(WINDOW_BYTES - 1))
                                      ? '0 : wp_reg + HIST_AW'(1);
                    if (produced_reg < CNT_W'(WINDOW_BYTES))
                    begin
                        produced_next = produced_reg + CNT_W'(1);
                    end
                    copy_next       = copy_reg - 32'd1;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_BYTE;
                    out_byte_next   = hist_rdata;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            phase_reg      <= PH_INIT;
            clr_reg        <= '0;
            idx_reg        <= '0;
            lit_reg        <= 1'b0;
            prob_reg       <= '0;
            copy_rd_reg    <= 1'b0;
            wp_reg         <= '0;
            hidx_reg       <= '0;
            produced_reg   <= '0;
            last_off_reg   <= '0;
            after_reg      <= 1'b0;
            copy_reg       <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            init_left_reg  <= 3'd4;
            gamma_reg      <= 32'd1;
            gctx_reg       <= 8'd1;
            tree_reg       <= 9'd1;
            offs_reg       <= '0;
            bonus_en_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_BYTE;
            out_byte_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            clr_reg        <= clr_next;
            idx_reg        <= idx_next;
            lit_reg        <= lit_next;
            prob_reg       <= prob_next;
            copy_rd_reg    <= copy_rd_next;
            wp_reg         <= wp_next;
            hidx_reg       <= hidx_next;
            produced_reg   <= produced_next;
            last_off_reg   <= last_off_next;
            after_reg      <= after_next;
            copy_reg       <= copy_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            init_left_reg  <= init_left_next;
            gamma_reg      <= gamma_next;
            gctx_reg       <= gctx_next;
            tree_reg       <= tree_next;
            offs_reg       <= offs_next;
            bonus_en_reg   <= bonus_en_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_byte_reg   <= out_byte_next;
        end
    end

endmodule

[rtl/lzbad_ram.sv]
// generic single write port ram with registered read
module lzbad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/lzbad_coder.sv]
// range coder datapath: code and range registers, bound multiplier, model update
module lzbad_coder
    import lzbad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  coder_cmd_t  cmd,
    output coder_stat_t stat
);

    logic [31:0] code_reg, code_next;
    logic [31:0] range_reg, range_next;
    logic [31:0] bound_reg, bound_next;
    logic [PROB_W:0] up_delta;
    logic [PROB_W-1:0] down_delta;
    logic bit_one;

    assign bit_one = (code_reg >= bound_reg);

    always_comb
    begin
        up_delta   = (PROB_W + 1)'(PROB_ONE) - {1'b0, cmd.prob};
        down_delta = cmd.prob;
        if (cmd.lit_shift)
        begin
            up_delta   = up_delta >> 4;
            down_delta = down_delta >> 4;
        end
        else
        begin
            up_delta   = up_delta >> 5;
            down_delta = down_delta >> 5;
        end
    end

    assign stat.need_norm = (range_reg < RANGE_TOP);
    assign stat.bit_val   = bit_one;
    assign stat.new_prob  = bit_one ? (cmd.prob - down_delta)
                                    : (cmd.prob + up_delta[PROB_W-1:0]);

    always_comb
    begin
        code_next  = code_reg;
        range_next = range_reg;
        bound_next = bound_reg;
        unique case (cmd.op)
            CO_NONE:
            begin
            end
            CO_RESET:
            begin
                code_next  = '0;
                range_next = '1;
            end
            CO_LOAD:
            begin
                code_next = {code_reg[23:0], cmd.data};
            end
            CO_NORM:
            begin
                code_next  = {code_reg[23:0], cmd.data};
                range_next = {range_reg[23:0], 8'd0};
            end
            CO_MUL:
            begin
                bound_next = range_reg[31:11] * cmd.prob;
            end
            CO_RESOLVE:
            begin
                if (bit_one)
                begin
                    code_next  = code_reg - bound_reg;
                    range_next = range_reg - bound_reg;
                end
                else
                begin
                    range_next = bound_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg  <= '0;
            range_reg <= '1;
        end
        else
        begin
            code_reg  <= code_next;
            range_reg <= range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
    end

endmodule

[sim/tb.sv]
// self-checking testbench for the lz binary arithmetic decoder, with a built-in decode predictor
module tb;
    import lzbad_pkg::*;

    typedef enum int {
        PH_INIT, PH_CODE, PH_LIT, PH_PREV, PH_G0A, PH_G0B, PH_LOW,
        PH_G1A, PH_G1B, PH_COPY, PH_END, PH_ERR
    } phase_t;

    typedef struct {
        logic [1:0] action;
        logic [7:0] data;
        bit         fixed;
        logic [2:0] status;
        logic [7:0] out_byte;
    } stim_row_t;

    typedef struct {
        logic [2:0] status;
        logic [7:0] out_byte;
    } decode_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lzbad_req_if request ();
    lzbad_res_if result ();

    lz_binary_arith_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request.sink),
        .result  (result.source)
    );

    always #1 clk = ~clk;

    // decoder state mirror
    logic [31:0]       dec_code;
    logic [31:0]       dec_range;
    logic [PROB_W-1:0] dec_prob [NUM_MODELS];
    logic [7:0]        dec_hist [WINDOW_BYTES];
    logic [31:0]       dec_wptr;
    logic [31:0]       dec_produced;
    logic [31:0]       dec_last_offs;
    logic              dec_after_match;
    logic [31:0]       dec_copy_left;
    phase_t            dec_phase;
    logic [7:0]        dec_held;
    logic              dec_held_valid;
    int                dec_init_left;
    logic [31:0]       dec_gamma;
    logic [7:0]        dec_gamma_ctx;
    logic [8:0]        dec_tree;

    decode_out_t expected_q [$];
    int  errors = 0;
    int  req_count = 0;
    int  res_count = 0;
    int  n_bytes = 0, n_need = 0, n_end = 0, n_err = 0, n_refused = 0;

    bit         cur_fixed;
    logic [2:0] cur_status;
    logic [7:0] cur_out;

    function automatic void decoder_clear();
        dec_code = '0;
        dec_range = 32'hFFFF_FFFF;
        for (int i = 0; i < NUM_MODELS; i++)
            dec_prob[i] = PROB_INIT;
        dec_wptr = '0;
        dec_produced = '0;
        dec_last_offs = '0;
        dec_after_match = 1'b0;
        dec_copy_left = '0;
        dec_phase = PH_INIT;
        dec_held = '0;
        dec_held_valid = 1'b0;
        dec_init_left = 4;
        dec_gamma = 32'd1;
        dec_gamma_ctx = 8'd1;
        dec_tree = 9'd1;
    endfunction

    // -1 when a renormalization byte is missing
    function automatic int coded_bit(int idx, int shift);
        logic [31:0] p;
        logic [31:0] bound;
        if (idx >= NUM_MODELS)
            idx = 0;
        if (dec_range < RANGE_TOP)
        begin
            if (!dec_held_valid)
                return -1;
            dec_code = {dec_code[23:0], dec_held};
            dec_range = dec_range << 8;
            dec_held_valid = 1'b0;
        end
        p = dec_prob[idx];
        bound = (dec_range >> 11) * p;
        if (dec_code < bound)
        begin
            dec_range = bound;
            dec_prob[idx] = p + ((PROB_ONE - p) >> shift);
            return 0;
        end
        dec_code = dec_code - bound;
        dec_range = dec_range - bound;
        dec_prob[idx] = p - (p >> shift);
        return 1;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        dec_hist[dec_wptr] = b;
        dec_wptr = (dec_wptr + 1 >= WINDOW_BYTES) ? 0 : dec_wptr + 1;
        if (dec_produced < WINDOW_BYTES)
            dec_produced++;
    endfunction

    function automatic void begin_gamma(phase_t ph);
        dec_gamma = 32'd1;
        dec_gamma_ctx = 8'd1;
        dec_phase = ph;
    endfunction

    function automatic void accept_offset(longint offs, int bonus);
        if (offs == 0 || offs > dec_produced)
        begin
            dec_phase = PH_ERR;
            return;
        end
        dec_last_offs = offs[31:0];
        dec_after_match = 1'b1;
        dec_copy_left = bonus;
        begin_gamma(PH_G1A);
    endfunction

    function automatic logic [2:0] decode_pull(output logic [7:0] b);
        int bt;
        int base;
        logic [31:0] t;
        longint offs;
        logic [31:0] hidx;
        b = '0;
        forever
        begin
            case (dec_phase)
                PH_INIT: return ST_NEED;
                PH_END: return ST_END;
                PH_CODE:
                begin
                    bt = coded_bit(dec_after_match ? 1 : 0, 5);
                    if (bt < 0)
                        return ST_NEED;
                    if (bt == 0)
                    begin
                        dec_tree = 9'd1;
                        dec_phase = PH_LIT;
                    end
                    else if (dec_after_match)
                        begin_gamma(PH_G0A);
                    else
                        dec_phase = PH_PREV;
                end
                PH_LIT:
                begin
                    bt = coded_bit(MODEL_LIT + dec_tree[7:0], 4);
                    if (bt < 0)
                        return ST_NEED;
                    dec_tree = {dec_tree[7:0], bt[0]};
                    if (dec_tree >= 256)
                    begin
                        b = dec_tree[7:0];
                        put_byte(b);
                        dec_after_match = 1'b0;
                        dec_phase = PH_CODE;
                        return ST_BYTE;
                    end
                end
                PH_PREV:
                begin
                    bt = coded_bit(MODEL_PREV, 5);
                    if (bt < 0)
                        return ST_NEED;
                    if (bt != 0)
                        accept_offset(dec_last_offs, 0);
                    else
                        begin_gamma(PH_G0A);
                end
                PH_G0A, PH_G1A:
                begin
                    base = (dec_phase == PH_G0A) ? MODEL_G0 : MODEL_G1;
                    bt = coded_bit(base + dec_gamma_ctx, 5);
                    if (bt < 0)
                        return ST_NEED;
                    dec_gamma_ctx = (dec_gamma_ctx << 1) + bt[0];
                    dec_phase = (dec_phase == PH_G0A) ? PH_G0B : PH_G1B;
                end
                PH_G0B, PH_G1B:
                begin
                    base = (dec_phase == PH_G0B) ? MODEL_G0 : MODEL_G1;
                    bt = coded_bit(base + dec_gamma_ctx, 5);
                    if (bt < 0)
                        return ST_NEED;
                    dec_gamma = (dec_gamma << 1) + bt[0];
                    dec_gamma_ctx = (dec_gamma_ctx << 1) + dec_gamma[0];
                    if (dec_gamma_ctx[1])
                        dec_phase = (dec_phase == PH_G0B) ? PH_G0A : PH_G1A;
                    else if (dec_phase == PH_G0B)
                    begin
                        if (dec_gamma == 0)
                            dec_phase = PH_END;
                        else
                        begin
                            dec_tree = 9'd1;
                            dec_phase = PH_LOW;
                        end
                    end
                    else
                    begin
                        dec_copy_left = dec_copy_left + dec_gamma;
                        dec_phase = PH_COPY;
                    end
                end
                PH_LOW:
                begin
                    t = dec_gamma - 32'd2;
                    base = MODEL_LOW + ((t != 0) ? 16 : 0);
                    bt = coded_bit(base + dec_tree[3:0], 5);
                    if (bt < 0)
                        return ST_NEED;
                    dec_tree = {dec_tree[7:0], bt[0]};
                    if (dec_tree >= 16)
                    begin
                        offs = (longint'(t) << 4) + longint'(dec_tree - 16) + 1;
                        accept_offset(offs, (offs >= 2048 ? 1 : 0) + (offs >= 96 ? 1 : 0));
                    end
                end
                PH_COPY:
                begin
                    if (dec_copy_left == 0)
                        dec_phase = PH_CODE;
                    else
                    begin
                        if (dec_last_offs == 0 || dec_last_offs > WINDOW_BYTES)
                        begin
                            dec_phase = PH_ERR;
                            return ST_OFFS_ERR;
                        end
                        hidx = (dec_wptr + WINDOW_BYTES - dec_last_offs) % WINDOW_BYTES;
                        b = dec_hist[hidx];
                        put_byte(b);
                        dec_copy_left--;
                        return ST_BYTE;
                    end
                end
                default:
                begin
                    dec_phase = PH_ERR;
                    return ST_OFFS_ERR;
                end
            endcase
        end
    endfunction

    function automatic decode_out_t decode_step(logic [1:0] act, logic [7:0] b);
        decode_out_t r;
        r.status = ST_REFUSED;
        r.out_byte = '0;
        if (act == ACT_RESTART)
        begin
            decoder_clear();
            r.status = ST_ACCEPTED;
        end
        else if (act == ACT_SUPPLY)
        begin
            if (dec_phase == PH_END || dec_phase == PH_ERR)
                r.status = ST_REFUSED;
            else if (dec_phase == PH_INIT)
            begin
                dec_code = {dec_code[23:0], b};
                if (dec_init_left > 0)
                    dec_init_left--;
                if (dec_init_left == 0)
                begin
                    dec_tree = 9'd1;
                    dec_phase = PH_LIT;
                end
                r.status = ST_ACCEPTED;
            end
            else if (dec_held_valid)
                r.status = ST_REFUSED;
            else
            begin
                dec_held = b;
                dec_held_valid = 1'b1;
                r.status = ST_ACCEPTED;
            end
        end
        else if (act == ACT_PULL)
        begin
            r.status = decode_pull(r.out_byte);
            if (r.status != ST_BYTE)
                r.out_byte = '0;
        end
        return r;
    endfunction

    // request acceptance and result checking
    always @(posedge clk)
    begin
        decode_out_t pred;
        decode_out_t want;
        if (rst_n && request.valid && request.ready)
        begin
            pred = decode_step(request.action, request.in_byte);
            want = pred;
            if (cur_fixed)
            begin
                want.status = cur_status;
                want.out_byte = cur_out;
            end
            expected_q.push_back(want);
            req_count++;
        end
        if (rst_n && result.valid && result.ready)
        begin
            res_count++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result status %0d byte %02h", $time,
                         result.status, result.out_byte);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.status !== want.status || result.out_byte !== want.out_byte)
                begin
                    $display("%0t: mismatch expected status %0d byte %02h, %s %0d byte %02h",
                             $time, want.status, want.out_byte, "got status",
                             result.status, result.out_byte);
                    errors++;
                end
                case (want.status)
                    ST_BYTE: n_bytes++;
                    ST_NEED: n_need++;
                    ST_END: n_end++;
                    ST_OFFS_ERR: n_err++;
                    ST_REFUSED: n_refused++;
                    default: ;
                endcase
            end
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: result.ready <= 1'b1;
            1: result.ready <= ($urandom_range(0, 3) != 0);
            default: result.ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    int burst_left = 0;

    task automatic send(logic [1:0] act, logic [7:0] b, bit fixed = 0,
                        logic [2:0] st = '0, logic [7:0] ob = '0);
        int seen;
        if (burst_left == 0)
        begin
            request.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        request.valid = 1'b1;
        request.action = act;
        request.in_byte = b;
        cur_fixed = fixed;
        cur_status = st;
        cur_out = ob;
        seen = req_count;
        do
            @(negedge clk);
        while (req_count == seen);
        request.valid = 1'b0;
    endtask

    stim_row_t directed [23] = '{
        '{ACT_PULL,    8'h00, 1, ST_NEED,     8'h00},
        '{2'd3,        8'hFF, 1, ST_REFUSED,  8'h00},
        '{ACT_SUPPLY,  8'h00, 1, ST_ACCEPTED, 8'h00},
        '{ACT_PULL,    8'h00, 1, ST_NEED,     8'h00},
        '{ACT_SUPPLY,  8'hFF, 1, ST_ACCEPTED, 8'h00},
        '{ACT_SUPPLY,  8'h80, 1, ST_ACCEPTED, 8'h00},
        '{ACT_SUPPLY,  8'h01, 1, ST_ACCEPTED, 8'h00},
        '{ACT_PULL,    8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_PULL,    8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_SUPPLY,  8'h5A, 0, ST_BYTE,     8'h00},
        '{ACT_SUPPLY,  8'hA5, 0, ST_BYTE,     8'h00},
        '{ACT_PULL,    8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_PULL,    8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_RESTART, 8'h00, 1, ST_ACCEPTED, 8'h00},
        '{ACT_SUPPLY,  8'hFF, 1, ST_ACCEPTED, 8'h00},
        '{ACT_SUPPLY,  8'hFF, 1, ST_ACCEPTED, 8'h00},
        '{ACT_SUPPLY,  8'hFF, 1, ST_ACCEPTED, 8'h00},
        '{ACT_SUPPLY,  8'hFF, 1, ST_ACCEPTED, 8'h00},
        '{ACT_PULL,    8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_PULL,    8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_SUPPLY,  8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_PULL,    8'h00, 0, ST_BYTE,     8'h00},
        '{ACT_RESTART, 8'h00, 1, ST_ACCEPTED, 8'h00}
    };

    initial
    begin
        int roll;
        int wait_cycles;
        request.valid = 1'b0;
        request.action = ACT_PULL;
        request.in_byte = '0;
        decoder_clear();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send(directed[i].action, directed[i].data, directed[i].fixed,
                 directed[i].status, directed[i].out_byte);

        for (int n = 0; n < 1200; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send(2'd3, 8'($urandom));
            else if (dec_phase == PH_END || dec_phase == PH_ERR || roll < 6)
                send((roll < 5 || roll > 50) ? ACT_RESTART : 2'($urandom_range(0, 1)),
                     8'($urandom));
            else if (dec_phase == PH_INIT || (!dec_held_valid && roll < 55))
                send(ACT_SUPPLY, 8'($urandom));
            else if (roll < 9)
                send(ACT_SUPPLY, 8'($urandom));
            else
                send(ACT_PULL, 8'($urandom));
        end

        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 200000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (100) @(negedge clk);
        $display("%0d requests, %0d results: %0d bytes, %0d need input, %0d refused",
                 req_count, res_count, n_bytes, n_need, n_refused);
        $display("streams ended %0d times, offset errors %0d", n_end, n_err);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("timeout");
        $display("tb NOT OK");
        $finish;
    end

endmodule

[files.f]
rtl/lzbad_pkg.sv
rtl/lzbad_if.sv
rtl/lzbad_ram.sv
rtl/lzbad_coder.sv
rtl/lz_binary_arith_decoder.sv
sim/tb.sv
